[src/triangle_unit_normal_assert.svh]
// ----------------------------------------------------------------------------
// triangle unit normal assertion macros
// property shorthands used by the top level checks
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_UNIT_NORMAL_ASSERT_SVH
`define TRIANGLE_UNIT_NORMAL_ASSERT_SVH

// same-cycle implication
`define TUN_ASSERT_HOLD(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("triangle_unit_normal: check failed");

// next-cycle implication
`define TUN_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("triangle_unit_normal: check failed");

`endif

[src/tun_pkg.sv]
// ----------------------------------------------------------------------------
// tun_pkg
// shared constants and types of the triangle unit normal pipeline
// ----------------------------------------------------------------------------
package tun_pkg;

	// magnitude limit below which the exact squared length is checked
	localparam int SMALL_BITS  = 21;
	// significant bits of the largest component after normalization
	localparam int SCALE_BITS  = 30;
	localparam int THRESH_BITS = 40;
	localparam int SUMSQ_BITS  = 2 * SCALE_BITS + 2;
	localparam int ROOT_BITS   = SCALE_BITS + 1;

	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_IDX_W  = CFG_ADDR_W - 3;

	localparam logic [CFG_IDX_W-1:0] IDX_THRESH = CFG_IDX_W'(0);

	typedef struct packed {
		logic neg_x;
		logic neg_y;
		logic neg_z;
		logic deg;
	} flags_t;

	typedef struct packed {
		logic [SCALE_BITS-1:0] cx;
		logic [SCALE_BITS-1:0] cy;
		logic [SCALE_BITS-1:0] cz;
		flags_t                fl;
	} sq_side_t;

endpackage

[src/tun_if.sv]
// ----------------------------------------------------------------------------
// tun_if
// valid/ready channels for triangle words and normal words
// ----------------------------------------------------------------------------
interface tun_vtx_if #(parameter int COORD_BITS = 20);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] a_x;
	logic signed [COORD_BITS-1:0] a_y;
	logic signed [COORD_BITS-1:0] a_z;
	logic signed [COORD_BITS-1:0] b_x;
	logic signed [COORD_BITS-1:0] b_y;
	logic signed [COORD_BITS-1:0] b_z;
	logic signed [COORD_BITS-1:0] c_x;
	logic signed [COORD_BITS-1:0] c_y;
	logic signed [COORD_BITS-1:0] c_z;

	modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		input ready);
	modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		output ready);
endinterface

interface tun_nrm_if #(parameter int OUT_BITS = 16);
	logic                       valid;
	logic                       ready;
	logic signed [OUT_BITS-1:0] unit_x;
	logic signed [OUT_BITS-1:0] unit_y;
	logic signed [OUT_BITS-1:0] unit_z;
	logic                       degenerate;

	modport source (output valid, unit_x, unit_y, unit_z, degenerate, input ready);
	modport sink (input valid, unit_x, unit_y, unit_z, degenerate, output ready);
endinterface

[src/triangle_unit_normal.sv]
// ----------------------------------------------------------------------------
// triangle_unit_normal
// unit face normal of one triangle with a degenerate check
// ----------------------------------------------------------------------------
// Unless stalled, takes one triangle word per clock and returns its unit
// normal in signed Q1.NORMAL_FRAC_BITS, one word per clock, in order. The
// pipe has seven stages for edges, cross product, squared length and
// normalizing shift, the 31-stage square root, one stage to form the
// numerators, one quotient bit per stage in the divider and the output
// register. The output register plus a one-word skid buffer let a new word
// in while a result waits; a stall freezes the whole pipe.
// degenerate_threshold lives at byte address 0 of the APB port.
module triangle_unit_normal import tun_pkg::*; #(
	parameter int COORD_BITS       = 20,
	parameter int NORMAL_FRAC_BITS = 15
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	tun_vtx_if.sink               vtx,
	tun_nrm_if.source             nrm
);

	localparam int EW    = COORD_BITS + 1;
	localparam int PW    = 2 * EW;
	localparam int MAG_W = PW - 1;
	localparam int LEN_W = $clog2(MAG_W + 1);
	localparam int WD    = MAG_W + SCALE_BITS;
	localparam int SQ_W  = 2 * SMALL_BITS;
	localparam int SQS_W = SQ_W + 2;
	localparam int CSQ_W = 2 * SCALE_BITS;
	localparam int QB    = NORMAL_FRAC_BITS + 1;
	localparam int NUM_W = SCALE_BITS + NORMAL_FRAC_BITS + 1;
	localparam int OW    = NORMAL_FRAC_BITS + 1;

	localparam logic [QB-1:0] QMAX = QB'((1 << NORMAL_FRAC_BITS) - 1);
	localparam logic signed [OW-1:0] OUT_MIN = {1'b1, {NORMAL_FRAC_BITS{1'b0}}};

	typedef struct packed {
		logic signed [OW-1:0] ux;
		logic signed [OW-1:0] uy;
		logic signed [OW-1:0] uz;
		logic                 deg;
	} res_t;

	function automatic logic [LEN_W-1:0] bit_len(input logic [MAG_W-1:0] v);
		logic [LEN_W-1:0] n;
		n = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (v[i]) begin
				n = LEN_W'(i + 1);
			end
		end
		return n;
	endfunction

	logic                   en;
	logic [THRESH_BITS-1:0] thresh_q;
	logic                   cfg_idx_hit;

	// ---------------- configuration ----------------
	assign cfg_idx_hit = (paddr[CFG_ADDR_W-1:3] == IDX_THRESH);
	assign pready      = 1'b1;
	assign prdata      = cfg_idx_hit ? CFG_DATA_W'(thresh_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= '0;
		end else if (psel && penable && pwrite && cfg_idx_hit) begin
			thresh_q <= pwdata[THRESH_BITS-1:0];
		end
	end

	// ---------------- front stages ----------------
	logic                 vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic signed [EW-1:0] e1_s1 [3];
	logic signed [EW-1:0] e2_s1 [3];
	logic signed [PW-1:0] pa_s2 [3];
	logic signed [PW-1:0] pb_s2 [3];
	logic [MAG_W-1:0]     mag_s3 [3];
	logic                 neg_s3 [3];
	logic [MAG_W-1:0]     mag_s4 [3];
	logic                 neg_s4 [3];
	logic [SQ_W-1:0]      sq_s4 [3];
	logic [LEN_W-1:0]     blen_s4;
	logic                 small_s4;
	logic [SCALE_BITS-1:0] c_s5 [3];
	flags_t               fl_s5;
	logic [SCALE_BITS-1:0] c_s6 [3];
	logic [CSQ_W-1:0]     csq_s6 [3];
	flags_t               fl_s6;
	logic [SUMSQ_BITS-1:0] s2_s7;
	sq_side_t             side_s7;

	logic signed [PW-1:0] n_c [3];
	logic [SQS_W-1:0]     sqsum_c;
	logic [SCALE_BITS-1:0] c_c [3];
	logic [WD-1:0]        wide_c;
	logic                 deg_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vtx.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			n_c[i] = pa_s2[i] - pb_s2[i];
		end
		sqsum_c = SQS_W'(sq_s4[0]) + SQS_W'(sq_s4[1]) + SQS_W'(sq_s4[2]);
		deg_c = small_s4 && (sqsum_c <= SQS_W'(thresh_q));
		wide_c = '0;
		for (int i = 0; i < 3; i++) begin
			// bring the largest component to exactly SCALE_BITS significant bits
			if (int'(blen_s4) >= SCALE_BITS) begin
				wide_c = WD'(mag_s4[i]) >> (int'(blen_s4) - SCALE_BITS);
			end else begin
				wide_c = WD'(mag_s4[i]) << (SCALE_BITS - int'(blen_s4));
			end
			c_c[i] = wide_c[SCALE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e1_s1[0] <= EW'(vtx.b_x) - EW'(vtx.a_x);
			e1_s1[1] <= EW'(vtx.b_y) - EW'(vtx.a_y);
			e1_s1[2] <= EW'(vtx.b_z) - EW'(vtx.a_z);
			e2_s1[0] <= EW'(vtx.c_x) - EW'(vtx.a_x);
			e2_s1[1] <= EW'(vtx.c_y) - EW'(vtx.a_y);
			e2_s1[2] <= EW'(vtx.c_z) - EW'(vtx.a_z);

			pa_s2[0] <= e1_s1[1] * e2_s1[2];
			pb_s2[0] <= e1_s1[2] * e2_s1[1];
			pa_s2[1] <= e1_s1[2] * e2_s1[0];
			pb_s2[1] <= e1_s1[0] * e2_s1[2];
			pa_s2[2] <= e1_s1[0] * e2_s1[1];
			pb_s2[2] <= e1_s1[1] * e2_s1[0];

			for (int i = 0; i < 3; i++) begin
				neg_s3[i] <= n_c[i][PW-1];
				mag_s3[i] <= n_c[i][PW-1] ? MAG_W'(-n_c[i]) : MAG_W'(n_c[i]);
			end

			for (int i = 0; i < 3; i++) begin
				mag_s4[i] <= mag_s3[i];
				neg_s4[i] <= neg_s3[i];
				sq_s4[i]  <= SQ_W'(SMALL_BITS'(mag_s3[i])) * SQ_W'(SMALL_BITS'(mag_s3[i]));
			end
			blen_s4  <= bit_len(mag_s3[0] | mag_s3[1] | mag_s3[2]);
			small_s4 <= ((mag_s3[0] | mag_s3[1] | mag_s3[2]) >> SMALL_BITS) == '0;

			for (int i = 0; i < 3; i++) begin
				c_s5[i] <= c_c[i];
			end
			fl_s5.neg_x <= neg_s4[0];
			fl_s5.neg_y <= neg_s4[1];
			fl_s5.neg_z <= neg_s4[2];
			fl_s5.deg   <= deg_c;

			for (int i = 0; i < 3; i++) begin
				c_s6[i]   <= c_s5[i];
				csq_s6[i] <= CSQ_W'(c_s5[i]) * CSQ_W'(c_s5[i]);
			end
			fl_s6 <= fl_s5;

			s2_s7 <= SUMSQ_BITS'(csq_s6[0]) + SUMSQ_BITS'(csq_s6[1])
				+ SUMSQ_BITS'(csq_s6[2]);
			side_s7.cx <= c_s6[0];
			side_s7.cy <= c_s6[1];
			side_s7.cz <= c_s6[2];
			side_s7.fl <= fl_s6;
		end
	end

	// ---------------- square root ----------------
	logic                 sq_vld;
	logic [ROOT_BITS-1:0] len;
	sq_side_t             sq_side;

	tun_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s7),
		.rad      (s2_s7),
		.in_side  (side_s7),
		.out_vld  (sq_vld),
		.root     (len),
		.out_side (sq_side)
	);

	// ---------------- numerators, rounded half up ----------------
	logic [NUM_W-1:0]     num_s8 [3];
	logic [ROOT_BITS-1:0] len_s8;
	flags_t               fl_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s8[0] <= (NUM_W'(sq_side.cx) << NORMAL_FRAC_BITS) + NUM_W'(len >> 1);
			num_s8[1] <= (NUM_W'(sq_side.cy) << NORMAL_FRAC_BITS) + NUM_W'(len >> 1);
			num_s8[2] <= (NUM_W'(sq_side.cz) << NORMAL_FRAC_BITS) + NUM_W'(len >> 1);
			len_s8    <= len;
			fl_s8     <= sq_side.fl;
		end
	end

	// ---------------- divide ----------------
	logic          dv_vld;
	logic [QB-1:0] quo [3];
	flags_t        dv_fl;

	tun_div #(
		.FRAC_BITS (NORMAL_FRAC_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s8),
		.num     (num_s8),
		.den     (len_s8),
		.in_fl   (fl_s8),
		.out_vld (dv_vld),
		.quo     (quo),
		.out_fl  (dv_fl)
	);

	// ---------------- saturate, sign, output word ----------------
	res_t             fin_c;
	logic [QB-1:0]    sat_c [3];
	logic signed [OW-1:0] val_c [3];
	logic             negs_c [3];

	always_comb begin
		negs_c[0] = dv_fl.neg_x;
		negs_c[1] = dv_fl.neg_y;
		negs_c[2] = dv_fl.neg_z;
		for (int i = 0; i < 3; i++) begin
			sat_c[i] = (quo[i] > QMAX) ? QMAX : quo[i];
			if (dv_fl.deg) begin
				val_c[i] = '0;
			end else if (negs_c[i]) begin
				val_c[i] = OW'(-sat_c[i]);
			end else begin
				val_c[i] = OW'(sat_c[i]);
			end
		end
		fin_c.ux  = val_c[0];
		fin_c.uy  = val_c[1];
		fin_c.uz  = val_c[2];
		fin_c.deg = dv_fl.deg;
	end

	logic out_vld_q, sk_vld_q;
	res_t out_q, sk_q;
	logic ld_out_fin, ld_out_sk, ld_sk;

	assign en         = !sk_vld_q;
	assign vtx.ready  = en;
	assign ld_out_fin = en && dv_vld && (!out_vld_q || nrm.ready);
	assign ld_sk      = en && dv_vld && out_vld_q && !nrm.ready;
	assign ld_out_sk  = !en && nrm.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			sk_vld_q  <= 1'b0;
		end else begin
			if (ld_out_fin || ld_out_sk) begin
				out_vld_q <= 1'b1;
			end else if (nrm.ready) begin
				out_vld_q <= 1'b0;
			end
			if (ld_sk) begin
				sk_vld_q <= 1'b1;
			end else if (ld_out_sk) begin
				sk_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out_fin) begin
			out_q <= fin_c;
		end else if (ld_out_sk) begin
			out_q <= sk_q;
		end
		if (ld_sk) begin
			sk_q <= fin_c;
		end
	end

	assign nrm.valid      = out_vld_q;
	assign nrm.unit_x     = out_q.ux;
	assign nrm.unit_y     = out_q.uy;
	assign nrm.unit_z     = out_q.uz;
	assign nrm.degenerate = out_q.deg;

	// ---------------- checks ----------------
`include "triangle_unit_normal_assert.svh"

	`TUN_ASSERT_HOLD(a_deg_zero, nrm.valid && nrm.degenerate,
		nrm.unit_x == '0 && nrm.unit_y == '0 && nrm.unit_z == '0)
	`TUN_ASSERT_HOLD(a_no_min, nrm.valid,
		nrm.unit_x != OUT_MIN && nrm.unit_y != OUT_MIN && nrm.unit_z != OUT_MIN)
	`TUN_ASSERT_HOLD(a_skid_behind_out, sk_vld_q, out_vld_q)
	`TUN_ASSERT_NEXT(a_enter, vtx.valid && vtx.ready, vld_s1)

endmodule

[src/tun_sqrt.sv]
// ----------------------------------------------------------------------------
// tun_sqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module tun_sqrt import tun_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_vld,
	input  logic [SUMSQ_BITS-1:0] rad,
	input  sq_side_t              in_side,
	output logic                  out_vld,
	output logic [ROOT_BITS-1:0]  root,
	output sq_side_t              out_side
);

	localparam int REM_W = ROOT_BITS + 2;

	// index of each array is the stage number
	logic                  vld_s  [ROOT_BITS];
	logic [SUMSQ_BITS-1:0] rad_s  [ROOT_BITS];
	logic [REM_W-1:0]      rem_s  [ROOT_BITS];
	logic [ROOT_BITS-1:0]  root_s [ROOT_BITS];
	sq_side_t              side_s [ROOT_BITS];

	for (genvar k = 0; k < ROOT_BITS; k++) begin : g_step
		logic                  v_p;
		logic [SUMSQ_BITS-1:0] x_p;
		logic [REM_W-1:0]      r_p;
		logic [ROOT_BITS-1:0]  q_p;
		sq_side_t              sd_p;
		logic [REM_W-1:0]      r_try;
		logic [REM_W-1:0]      trial;
		logic [REM_W-1:0]      r_n;
		logic [ROOT_BITS-1:0]  q_n;

		if (k == 0) begin : g_first
			assign v_p  = in_vld;
			assign x_p  = rad;
			assign r_p  = '0;
			assign q_p  = '0;
			assign sd_p = in_side;
		end else begin : g_next
			assign v_p  = vld_s[k-1];
			assign x_p  = rad_s[k-1];
			assign r_p  = rem_s[k-1];
			assign q_p  = root_s[k-1];
			assign sd_p = side_s[k-1];
		end

		always_comb begin
			r_try = {r_p[REM_W-3:0], x_p[SUMSQ_BITS-1 -: 2]};
			trial = {q_p, 2'b01};
			if (r_try >= trial) begin
				r_n = r_try - trial;
				q_n = {q_p[ROOT_BITS-2:0], 1'b1};
			end else begin
				r_n = r_try;
				q_n = {q_p[ROOT_BITS-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= {x_p[SUMSQ_BITS-3:0], 2'b00};
				rem_s[k]  <= r_n;
				root_s[k] <= q_n;
				side_s[k] <= sd_p;
			end
		end
	end

	assign out_vld  = vld_s[ROOT_BITS-1];
	assign root     = root_s[ROOT_BITS-1];
	assign out_side = side_s[ROOT_BITS-1];

endmodule

[src/tun_div.sv]
// ----------------------------------------------------------------------------
// tun_div
// three-lane pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module tun_div import tun_pkg::*; #(
	parameter int FRAC_BITS = 15,
	localparam int QB    = FRAC_BITS + 1,
	localparam int NUM_W = SCALE_BITS + FRAC_BITS + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  logic [NUM_W-1:0]     num [3],
	input  logic [ROOT_BITS-1:0] den,
	input  flags_t               in_fl,
	output logic                 out_vld,
	output logic [QB-1:0]        quo [3],
	output flags_t               out_fl
);

	logic                 vld_s [QB];
	logic [ROOT_BITS-1:0] den_s [QB];
	flags_t               fl_s  [QB];
	logic [ROOT_BITS-1:0] rem_s [QB][3];
	logic [QB-1:0]        low_s [QB][3];
	logic [QB-1:0]        quo_s [QB][3];

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic                 v_p;
		logic [ROOT_BITS-1:0] d_p;
		flags_t               f_p;
		logic [ROOT_BITS-1:0] r_p [3];
		logic [QB-1:0]        l_p [3];
		logic [QB-1:0]        q_p [3];
		logic [ROOT_BITS:0]   r_try [3];
		logic [ROOT_BITS-1:0] r_n [3];
		logic [QB-1:0]        q_n [3];

		if (k == 0) begin : g_first
			assign v_p = in_vld;
			assign d_p = den;
			assign f_p = in_fl;
			always_comb begin
				for (int l = 0; l < 3; l++) begin
					// numerator is below den * 2^QB, so the upper part is a valid start
					r_p[l] = ROOT_BITS'(num[l][NUM_W-1:QB]);
					l_p[l] = num[l][QB-1:0];
					q_p[l] = '0;
				end
			end
		end else begin : g_next
			assign v_p = vld_s[k-1];
			assign d_p = den_s[k-1];
			assign f_p = fl_s[k-1];
			always_comb begin
				for (int l = 0; l < 3; l++) begin
					r_p[l] = rem_s[k-1][l];
					l_p[l] = low_s[k-1][l];
					q_p[l] = quo_s[k-1][l];
				end
			end
		end

		always_comb begin
			for (int l = 0; l < 3; l++) begin
				r_try[l] = {r_p[l], l_p[l][QB-1]};
				if (r_try[l] >= {1'b0, d_p}) begin
					r_n[l] = ROOT_BITS'(r_try[l] - {1'b0, d_p});
					q_n[l] = {q_p[l][QB-2:0], 1'b1};
				end else begin
					r_n[l] = ROOT_BITS'(r_try[l]);
					q_n[l] = {q_p[l][QB-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k] <= d_p;
				fl_s[k]  <= f_p;
				for (int l = 0; l < 3; l++) begin
					rem_s[k][l] <= r_n[l];
					low_s[k][l] <= {l_p[l][QB-2:0], 1'b0};
					quo_s[k][l] <= q_n[l];
				end
			end
		end
	end

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			quo[l] = quo_s[QB-1][l];
		end
	end

	assign out_vld = vld_s[QB-1];
	assign out_fl  = fl_s[QB-1];

endmodule

[verif/tb_triangle_unit_normal.sv]
// ----------------------------------------------------------------------------
// tb_triangle_unit_normal
// self-checking bench for the triangle unit normal pipeline: drives triangle
// words with random gaps, back-pressures the normal channel, predicts every
// normal word in an exact integer model and compares it field by field
// ----------------------------------------------------------------------------
module tb_triangle_unit_normal;
	import tun_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = 20;
	localparam int FB = 15;
	localparam logic [CFG_ADDR_W-1:0] ADDR_THRESH = CFG_ADDR_W'(IDX_THRESH) << 3;
	localparam longint unsigned THRESH_MAX = (64'd1 << THRESH_BITS) - 1;

	typedef logic signed [CB-1:0] coord_t;
	typedef coord_t tri_t [9];
	typedef struct {
		logic signed [15:0] ux;
		logic signed [15:0] uy;
		logic signed [15:0] uz;
		logic               deg;
	} normal_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata, prdata;
	logic pready;

	tun_vtx_if #(.COORD_BITS(CB)) vtx_ch ();
	tun_nrm_if #(.OUT_BITS(FB + 1)) nrm_ch ();

	triangle_unit_normal #(.COORD_BITS(CB), .NORMAL_FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.vtx(vtx_ch), .nrm(nrm_ch)
	);

	normal_t pending_normals[$];
	longint unsigned thresh_cfg;
	int mismatches = 0;
	bit idle_en = 1'b1;
	int hold_cycles = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("triangle_unit_normal verification failed");
		$finish;
	end

	// ---------------- predictor ----------------
	function automatic longint unsigned isqrt(longint unsigned x);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic normal_t face_normal(tri_t t);
		longint e1[3], e2[3], n[3];
		longint unsigned mag[3], c[3], sq, s2, len, q;
		logic [15:0] o[3];
		int bl, maxlen, sh;
		bit tiny;
		normal_t r;
		for (int i = 0; i < 3; i++) begin
			e1[i] = longint'(t[3+i]) - longint'(t[i]);
			e2[i] = longint'(t[6+i]) - longint'(t[i]);
		end
		n[0] = e1[1] * e2[2] - e1[2] * e2[1];
		n[1] = e1[2] * e2[0] - e1[0] * e2[2];
		n[2] = e1[0] * e2[1] - e1[1] * e2[0];
		tiny = 1'b1;
		sq = 0;
		maxlen = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = (n[i] < 0) ? -n[i] : n[i];
			bl = 0;
			while ((mag[i] >> bl) != 0) bl++;
			if (bl > maxlen) maxlen = bl;
			if (bl > SMALL_BITS) tiny = 1'b0;
			else sq += mag[i] * mag[i];
		end
		if (tiny && sq <= thresh_cfg) begin
			r.ux = 0; r.uy = 0; r.uz = 0; r.deg = 1'b1;
			return r;
		end
		sh = maxlen - SCALE_BITS;
		s2 = 0;
		for (int i = 0; i < 3; i++) begin
			c[i] = (sh > 0) ? (mag[i] >> sh) : (mag[i] << (-sh));
			s2 += c[i] * c[i];
		end
		len = isqrt(s2);
		for (int i = 0; i < 3; i++) begin
			q = (len != 0) ? ((c[i] << FB) + (len >> 1)) / len : 0;
			if (q > 32767) q = 32767;
			o[i] = (n[i] < 0) ? 16'(-q) : 16'(q);
		end
		r.ux = o[0]; r.uy = o[1]; r.uz = o[2]; r.deg = 1'b0;
		return r;
	endfunction

	// ---------------- result checker ----------------
	always @(posedge clk) begin
		normal_t e;
		if (arst_n && nrm_ch.valid && nrm_ch.ready) begin
			if (pending_normals.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected normal word %0d %0d %0d deg %0b",
					nrm_ch.unit_x, nrm_ch.unit_y, nrm_ch.unit_z, nrm_ch.degenerate);
			end else begin
				e = pending_normals.pop_front();
				if (nrm_ch.unit_x !== e.ux || nrm_ch.unit_y !== e.uy ||
						nrm_ch.unit_z !== e.uz || nrm_ch.degenerate !== e.deg) begin
					mismatches++;
					if (mismatches <= 10)
						$display("normal mismatch: exp %0d %0d %0d deg %0b got %0d %0d %0d deg %0b",
							e.ux, e.uy, e.uz, e.deg, nrm_ch.unit_x, nrm_ch.unit_y,
							nrm_ch.unit_z, nrm_ch.degenerate);
				end
			end
		end
	end

	// ---------------- receiver stalls ----------------
	initial begin
		nrm_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				nrm_ch.ready <= 1'b0;
				hold_cycles--;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				nrm_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				nrm_ch.ready <= 1'b1;
			end else begin
				nrm_ch.ready <= 1'b1;
			end
		end
	end

	// ---------------- drivers ----------------
	task automatic apb_write(logic [CFG_ADDR_W-1:0] addr, longint unsigned val);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (addr == ADDR_THRESH) thresh_cfg = val & THRESH_MAX;
		@(posedge clk);
	endtask

	task automatic apb_check(logic [CFG_ADDR_W-1:0] addr, longint unsigned exp_val);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[THRESH_BITS-1:0] !== exp_val[THRESH_BITS-1:0]) begin
			mismatches++;
			if (mismatches <= 10)
				$display("register readback: exp %0h got %0h", exp_val, prdata);
		end
		psel <= 1'b0; penable <= 1'b0;
	endtask

	task automatic send_tri(tri_t t);
		vtx_ch.valid <= 1'b1;
		{vtx_ch.a_x, vtx_ch.a_y, vtx_ch.a_z} <= {t[0], t[1], t[2]};
		{vtx_ch.b_x, vtx_ch.b_y, vtx_ch.b_z} <= {t[3], t[4], t[5]};
		{vtx_ch.c_x, vtx_ch.c_y, vtx_ch.c_z} <= {t[6], t[7], t[8]};
		do @(posedge clk); while (!vtx_ch.ready);
		pending_normals = {pending_normals, face_normal(t)};
		if (idle_en && $urandom_range(0, 4) == 0) begin
			vtx_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	task automatic stop_sending();
		vtx_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait for every normal word, then let the pipe run dry
	task automatic drain();
		stop_sending();
		while (pending_normals.size() != 0) @(posedge clk);
		repeat (70) @(posedge clk);
	endtask

	task automatic set_thresh(longint unsigned val);
		drain();
		apb_write(ADDR_THRESH, val);
		apb_check(ADDR_THRESH, val);
	endtask

	function automatic tri_t make_tri(int ax, int ay, int az, int bx, int by, int bz,
			int cx, int cy, int cz);
		tri_t t;
		t = '{coord_t'(ax), coord_t'(ay), coord_t'(az), coord_t'(bx), coord_t'(by),
			coord_t'(bz), coord_t'(cx), coord_t'(cy), coord_t'(cz)};
		return t;
	endfunction

	function automatic tri_t random_tri();
		tri_t t;
		int k, span;
		coord_t d[3];
		k = $urandom_range(0, 9);
		for (int i = 0; i < 9; i++) t[i] = coord_t'($urandom);
		if (k == 5 || k == 6 || k == 9) begin
			// small triangle near a random base, lands near the threshold
			span = (k == 9) ? 3 : (1 << $urandom_range(0, 11));
			for (int i = 3; i < 9; i++)
				t[i] = t[i % 3] + coord_t'($urandom_range(0, 2 * span) - span);
		end else if (k == 7) begin
			// collinear vertices
			for (int i = 0; i < 3; i++) begin
				d[i] = coord_t'($urandom_range(0, 2000) - 1000);
				t[3+i] = t[i] + d[i];
				t[6+i] = coord_t'(t[i] + 2 * d[i]);
			end
		end else if (k == 8) begin
			for (int i = 0; i < 9; i++)
				case ($urandom_range(0, 3))
					0: t[i] = coord_t'(-524288);
					1: t[i] = coord_t'(524287);
					2: t[i] = '0;
					default: t[i] = '1;
				endcase
		end
		return t;
	endfunction

	// ---------------- tests ----------------
	task automatic test_register_reset();
		apb_check(ADDR_THRESH, 0);
	endtask

	task automatic test_directed();
		set_thresh(0);
		send_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_tri(make_tri(5, 5, 5, 6, 7, 8, 7, 9, 11));
		send_tri(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
		send_tri(make_tri(0, 0, 0, 0, 1, 0, 1, 0, 0));
		send_tri(make_tri(0, 0, 0, 0, 1, 0, 0, 0, 1));
		send_tri(make_tri(0, 0, 0, 0, 0, 1, 1, 0, 0));
		send_tri(make_tri(0, 0, 0, 1, 1, 0, 0, 1, 1));
		send_tri(make_tri(-524288, -524288, -524288, 524287, 524287, -524288,
			-524288, 524287, 524287));
		send_tri(make_tri(524287, 524287, 524287, -524288, 524287, 524287,
			524287, -524288, -524288));
		send_tri(make_tri(-524288, 0, 524287, 524287, -524288, 0, 0, 524287, -524288));
		send_tri(make_tri(-1, -1, -1, -524288, -1, -1, -1, 524287, -1));
		send_tri(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 1));
		send_tri(make_tri(0, 0, 0, 3, 0, 0, 0, 4, 0));
		// threshold exactly at the squared length: degenerate
		set_thresh(144);
		send_tri(make_tri(0, 0, 0, 3, 0, 0, 0, 4, 0));
		send_tri(make_tri(0, 0, 0, 4, 0, 0, 0, -3, 0));
		set_thresh(143);
		send_tri(make_tri(0, 0, 0, 3, 0, 0, 0, 4, 0));
		// component just past the small range is never degenerate
		set_thresh(THRESH_MAX);
		send_tri(make_tri(0, 0, 0, 1024, 0, 0, 0, 1024, 0));
		send_tri(make_tri(0, 0, 0, 2048, 0, 0, 0, 1024, 0));
		send_tri(make_tri(0, 0, 0, 1000, 300, 0, 200, 1000, 100));
		send_tri(make_tri(-524288, -524288, -524288, 524287, 524287, -524288,
			-524288, 524287, 524287));
	endtask

	task automatic test_random_thresholds();
		longint unsigned th[4];
		th[0] = 0;
		th[1] = THRESH_MAX;
		th[2] = {$urandom, $urandom} & THRESH_MAX;
		th[3] = $urandom_range(0, 1 << 20);
		for (int p = 0; p < 4; p++) begin
			set_thresh(th[p]);
			repeat (200) send_tri(random_tri());
		end
	endtask

	task automatic test_backpressure();
		set_thresh($urandom_range(0, 1 << 16));
		hold_cycles = 400;
		repeat (100) send_tri(random_tri());
	endtask

	task automatic test_send_pause();
		repeat (20) send_tri(random_tri());
		stop_sending();
		while (pending_normals.size() != 0) @(posedge clk);
		repeat (30) send_tri(random_tri());
	endtask

	task automatic test_full_rate();
		idle_en = 1'b0;
		repeat (150) send_tri(random_tri());
	endtask

	initial begin
		thresh_cfg = 0;
		arst_n <= 1'b0;
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
		vtx_ch.valid <= 1'b0;
		{vtx_ch.a_x, vtx_ch.a_y, vtx_ch.a_z} <= '0;
		{vtx_ch.b_x, vtx_ch.b_y, vtx_ch.b_z} <= '0;
		{vtx_ch.c_x, vtx_ch.c_y, vtx_ch.c_z} <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_reset();
		test_directed();
		test_random_thresholds();
		test_backpressure();
		test_send_pause();
		test_full_rate();
		drain();
		if (mismatches == 0 && pending_normals.size() == 0)
			$display("triangle_unit_normal verification clean");
		else
			$display("triangle_unit_normal verification failed");
		$finish;
	end

endmodule

[filelist.f]
+incdir+src
src/tun_pkg.sv
src/tun_if.sv
src/tun_sqrt.sv
src/tun_div.sv
src/triangle_unit_normal.sv
verif/tb_triangle_unit_normal.sv
